### hdl/dpq_pkg.sv
// Shared types and codes for the double-ended priority queue.
`timescale 1ns / 1ps
`default_nettype none
package dpq_pkg;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CmdWidth   = 2;
   localparam int unsigned StatWidth  = 2;
   localparam int unsigned ReqWidth   = 40;
   localparam int unsigned RspWidth   = 40;

   typedef logic signed [ValueWidth-1:0] dpq_value_type;

   typedef enum logic [CmdWidth-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_EXT_MIN = 2'd1,
      CMD_EXT_MAX = 2'd2,
      CMD_SPARE   = 2'd3
   } dpq_cmd_type;

   typedef enum logic [StatWidth-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_RSVD  = 2'd3
   } dpq_status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic shift_down;
   } dpq_ctrl_type;

endpackage
`default_nettype wire

### hdl/dpq_cell.sv
// One slot of the sorted chain: compare with the new key and shift.
`timescale 1ns / 1ps
`default_nettype none
module dpq_cell
   import dpq_pkg::*;
(
   input  wire logic          clock,
   input  wire dpq_ctrl_type  ctrl,
   input  wire dpq_value_type key,
   input  wire dpq_value_type left_val,
   input  wire logic          left_gt,
   input  wire dpq_value_type right_val,
   input  wire logic          occupied,
   input  wire logic          is_end,
   input  wire logic          is_top,
   output dpq_value_type      val,
   output logic               gt,
   output dpq_value_type      tap
);

   dpq_value_type val_ff;
   dpq_value_type val_in;

   // strict compare keeps a new key behind equal entries
   assign gt  = occupied && (val_ff > key);
   assign val = val_ff;
   assign tap = is_top ? val_ff : '0;

   always_comb begin
      val_in = val_ff;
      if (ctrl.ins) begin
         if (left_gt) begin
            val_in = left_val;
         end else if (gt || is_end) begin
            val_in = key;
         end
      end else if (ctrl.shift_down) begin
         val_in = right_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule
`default_nettype wire

### hdl/double_ended_priority_queue.sv
// Top level: command decode, entry count, chain of sorted cells, result register.
// The response word is registered and is valid in the cycle after its request word is accepted.
// Throughput: one word per cycle while responses are taken; every cell updates in parallel.
// The request side stalls only while a finished response waits for rsp_tready.
// Reset clears the entry count and the response valid; cell contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_priority_queue
   import dpq_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqWidth-1:0] req_tdata,   // [1:0] cmd, [33:2] value_in, zero fill
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RspWidth-1:0]      rsp_tdata    // [31:0] value_out, [33:32] status, zero fill
);

   localparam int unsigned CntWidth = $clog2(CAPACITY + 1);

   logic [CntWidth-1:0] count_ff;
   logic [CntWidth-1:0] count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   dpq_value_type       rsp_value_ff;
   dpq_value_type       rsp_value_in;
   dpq_status_type      rsp_status_ff;
   dpq_status_type      rsp_status_in;

   logic          accept;
   dpq_cmd_type   cmd;
   dpq_value_type key;
   logic          full;
   logic          empty;
   dpq_ctrl_type  ctrl;
   dpq_value_type max_val;

   dpq_value_type cell_val [CAPACITY];
   logic          cell_gt  [CAPACITY];
   dpq_value_type cell_tap [CAPACITY];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = dpq_cmd_type'(req_tdata[CmdWidth-1:0]);
   assign key        = dpq_value_type'(req_tdata[CmdWidth +: ValueWidth]);
   assign full       = (count_ff == CntWidth'(CAPACITY));
   assign empty      = (count_ff == '0);

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         localparam logic [CntWidth-1:0] Idx  = CntWidth'(i);
         localparam logic [CntWidth-1:0] Idx1 = CntWidth'(i + 1);
         dpq_value_type left_val;
         logic          left_gt;
         dpq_value_type right_val;

         if (i == 0) begin : g_first
            assign left_val = '0;
            assign left_gt  = 1'b0;
         end else begin : g_mid
            assign left_val = cell_val[i-1];
            assign left_gt  = cell_gt[i-1];
         end
         if (i == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[i];
         end else begin : g_inner
            assign right_val = cell_val[i+1];
         end

         dpq_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .key       (key),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .occupied  (Idx < count_ff),
            .is_end    (count_ff == Idx),
            .is_top    (count_ff == Idx1),
            .val       (cell_val[i]),
            .gt        (cell_gt[i]),
            .tap       (cell_tap[i])
         );
      end
   endgenerate

   // only the top occupied cell drives a nonzero tap
   always_comb begin
      max_val = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         max_val = max_val | cell_tap[k];
      end
   end

   always_comb begin
      ctrl          = '0;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = STAT_OK;
         unique case (cmd)
            CMD_INSERT: begin
               if (full) begin
                  rsp_status_in = STAT_FULL;
               end else begin
                  ctrl.ins = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_EXT_MIN: begin
               if (empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  ctrl.shift_down = 1'b1;
                  rsp_value_in    = cell_val[0];
                  count_in        = count_ff - 1'b1;
               end
            end
            default: begin
               // max and the spare code: drop the top entry
               if (empty) begin
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  rsp_value_in = max_val;
                  count_in     = count_ff - 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspWidth - ValueWidth - StatWidth){1'b0}},
                        rsp_status_ff, rsp_value_ff};

endmodule
`default_nettype wire
